// ===== rtl/ritp_pkg.sv =====
// shared types, constants and codes for the return and indirect target predictor
package ritp_pkg;

    // payload widths
    localparam int ADDR_W = 64;
    localparam int KIND_W = 3;
    localparam int SIZE_W = 4;

    // default table sizes
    localparam int DEF_INDIRECT_ENTRIES  = 4096;
    localparam int DEF_RAS_DEPTH         = 32;
    localparam int DEF_CALL_SIZE_ENTRIES = 1024;

    // request codes
    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    // branch kinds
    localparam logic [KIND_W-1:0] KIND_NONE          = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DIRECT_JUMP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INDIRECT      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONDITIONAL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIRECT_CALL   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INDIRECT_CALL = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RETURN        = 3'd6;
    localparam logic [KIND_W-1:0] KIND_OTHER         = 3'd7;

    // call-size learning limits
    localparam logic [SIZE_W-1:0] MAX_LEARNED_SIZE = 4'd10;
    localparam logic [SIZE_W-1:0] RESET_CALL_SIZE  = 4'd4;
    localparam logic [ADDR_W-1:0] NEAR_LOW_LIMIT   = 64'(MAX_LEARNED_SIZE);
    localparam logic [ADDR_W-1:0] NEAR_HIGH_LIMIT  = ~NEAR_LOW_LIMIT + 64'd1;

    // return stack operations
    typedef struct packed {
        logic push;
        logic pop;
    } ritp_ras_op_t;

    // table operations
    typedef struct packed {
        logic ind_read;
        logic ind_write;
        logic hist_shift;
        logic size_read;
        logic size_learn;
    } ritp_tbl_op_t;

endpackage

// ===== rtl/ritp_ras.sv =====
// circular return address stack with its top pointer
module ritp_ras #(
    parameter int RAS_DEPTH = ritp_pkg::DEF_RAS_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ritp_pkg::ritp_ras_op_t      op,
    input  logic [ritp_pkg::ADDR_W-1:0] push_addr,
    output logic [ritp_pkg::ADDR_W-1:0] top
);

    localparam int SP_W = $clog2(RAS_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(RAS_DEPTH - 1);

    logic [ritp_pkg::ADDR_W-1:0] stack_reg [RAS_DEPTH];
    logic [SP_W-1:0]             sp_reg;
    logic [SP_W-1:0]             sp_up;
    logic [SP_W-1:0]             sp_down;
    logic [SP_W-1:0]             sp_next;

    // wrapping pointer moves
    assign sp_up   = (sp_reg == SP_LAST) ? '0 : sp_reg + SP_W'(1);
    assign sp_down = (sp_reg == '0) ? SP_LAST : sp_reg - SP_W'(1);

    always_comb
    begin
        sp_next = sp_reg;
        if (op.push)
        begin
            sp_next = sp_up;
        end
        else if (op.pop)
        begin
            sp_next = sp_down;
        end
    end

    assign top = stack_reg[sp_reg];

    // push writes above the top, pop clears the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            for (int i = 0; i < RAS_DEPTH; i++)
            begin
                stack_reg[i] <= '0;
            end
        end
        else
        begin
            sp_reg <= sp_next;
            if (op.push)
            begin
                stack_reg[sp_up] <= push_addr;
            end
            else if (op.pop)
            begin
                stack_reg[sp_reg] <= '0;
            end
        end
    end

endmodule

// ===== rtl/ritp_tables.sv =====
// indirect target table, call-size table, taken history and the clearing pass
module ritp_tables #(
    parameter int INDIRECT_ENTRIES  = ritp_pkg::DEF_INDIRECT_ENTRIES,
    parameter int CALL_SIZE_ENTRIES = ritp_pkg::DEF_CALL_SIZE_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ritp_pkg::ritp_tbl_op_t      op,
    input  logic [ritp_pkg::ADDR_W-1:0] branch_address,
    input  logic [ritp_pkg::ADDR_W-1:0] actual_target,
    input  logic                        was_taken,
    input  logic [ritp_pkg::ADDR_W-1:0] top,
    output logic [ritp_pkg::ADDR_W-1:0] ind_rdata,
    output logic [ritp_pkg::SIZE_W-1:0] size_rdata,
    output logic                        clearing
);

    localparam int IND_W  = $clog2(INDIRECT_ENTRIES);
    localparam int SIZE_IDX_W = $clog2(CALL_SIZE_ENTRIES);
    localparam int CLR_ENTRIES = (INDIRECT_ENTRIES > CALL_SIZE_ENTRIES) ?
                                 INDIRECT_ENTRIES : CALL_SIZE_ENTRIES;
    localparam int CLR_W = $clog2(CLR_ENTRIES);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_ENTRIES - 1);

    logic [ritp_pkg::ADDR_W-1:0] ind_mem [INDIRECT_ENTRIES];
    logic [ritp_pkg::SIZE_W-1:0] size_mem [CALL_SIZE_ENTRIES];

    logic [IND_W-1:0]            hist_reg;
    logic [CLR_W-1:0]            clr_cnt_reg;
    logic                        clearing_reg;

    logic [IND_W-1:0]            ind_idx;
    logic [IND_W-1:0]            ind_addr;
    logic                        ind_we;
    logic [ritp_pkg::ADDR_W-1:0] ind_wdata;
    logic [SIZE_IDX_W-1:0]       size_addr;
    logic                        size_we;
    logic [ritp_pkg::SIZE_W-1:0] size_wdata;
    logic [ritp_pkg::ADDR_W-1:0] diff;
    logic                        near_up;
    logic                        near_down;
    logic [ritp_pkg::SIZE_W-1:0] learn_size;

    assign clearing = clearing_reg;

    // table index: word address folded with the history
    assign ind_idx = branch_address[IND_W+1:2] ^ hist_reg;

    // distance between call and return target, wrapping subtract
    assign diff       = top - actual_target;
    assign near_up    = (diff <= ritp_pkg::NEAR_LOW_LIMIT);
    assign near_down  = (diff >= ritp_pkg::NEAR_HIGH_LIMIT);
    assign learn_size = near_up ? diff[ritp_pkg::SIZE_W-1:0]
                                : ritp_pkg::SIZE_W'(~diff[ritp_pkg::SIZE_W-1:0] + 4'd1);

    // port selection between the clearing pass and normal items
    always_comb
    begin
        if (clearing_reg)
        begin
            ind_addr   = clr_cnt_reg[IND_W-1:0];
            ind_we     = 1'b1;
            ind_wdata  = '0;
            size_addr  = clr_cnt_reg[SIZE_IDX_W-1:0];
            size_we    = 1'b1;
            size_wdata = ritp_pkg::RESET_CALL_SIZE;
        end
        else
        begin
            ind_addr   = ind_idx;
            ind_we     = op.ind_write;
            ind_wdata  = actual_target;
            size_addr  = top[SIZE_IDX_W-1:0];
            size_we    = op.size_learn && (near_up || near_down);
            size_wdata = learn_size;
        end
    end

    // history and clearing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg     <= '0;
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            if (op.hist_shift)
            begin
                hist_reg <= {hist_reg[IND_W-2:0], was_taken};
            end
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // indirect target memory
    always_ff @(posedge clk)
    begin
        if (ind_we)
        begin
            ind_mem[ind_addr] <= ind_wdata;
        end
        if (op.ind_read)
        begin
            ind_rdata <= ind_mem[ind_addr];
        end
    end

    // call-size memory
    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_addr] <= size_wdata;
        end
        if (op.size_read)
        begin
            size_rdata <= size_mem[size_addr];
        end
    end

endmodule

// ===== rtl/return_and_indirect_target_predictor_unit.sv =====
// top level: input register, state update stage, result register
// Items pass the input register, middle stage and result register in order.
// Throughput: one item per cycle if not stalled; independent stages close bubbles.
// Per item, the state update stage reads or writes each table memory at most once.
// Reset: stack and pointers clear at once; then a clearing pass fills both tables
// over max(INDIRECT_ENTRIES, CALL_SIZE_ENTRIES) addresses, with in_stall high.
module return_and_indirect_target_predictor_unit #(
    parameter int INDIRECT_ENTRIES  = ritp_pkg::DEF_INDIRECT_ENTRIES,
    parameter int RAS_DEPTH         = ritp_pkg::DEF_RAS_DEPTH,
    parameter int CALL_SIZE_ENTRIES = ritp_pkg::DEF_CALL_SIZE_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [ritp_pkg::KIND_W-1:0] branch_kind,
    input  logic [ritp_pkg::ADDR_W-1:0] branch_address,
    input  logic [ritp_pkg::ADDR_W-1:0] actual_target,
    input  logic                        was_taken,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ritp_pkg::ADDR_W-1:0] predicted_target,
    output logic                        served
);

    // input register
    logic                        e_valid_reg;
    logic                        func_reg;
    logic [ritp_pkg::KIND_W-1:0] kind_reg;
    logic [ritp_pkg::ADDR_W-1:0] addr_reg;
    logic [ritp_pkg::ADDR_W-1:0] target_reg;
    logic                        taken_reg;

    // middle stage
    logic                        m_valid_reg;
    logic                        m_served_reg;
    logic                        m_is_ret_reg;
    logic [ritp_pkg::ADDR_W-1:0] m_top_reg;

    // result register
    logic                        out_valid_reg;
    logic                        served_reg;
    logic [ritp_pkg::ADDR_W-1:0] pred_reg;
    logic [ritp_pkg::ADDR_W-1:0] pred_next;

    logic                        r_en;
    logic                        m_en;
    logic                        e_en;
    logic                        accept;
    logic                        fire;
    logic                        clearing;
    logic                        is_pred;
    logic                        is_call;
    logic                        is_ind;
    logic                        is_ret;
    logic [ritp_pkg::ADDR_W-1:0] top;
    logic [ritp_pkg::ADDR_W-1:0] ind_rdata;
    logic [ritp_pkg::SIZE_W-1:0] size_rdata;

    ritp_pkg::ritp_ras_op_t      ras_op;
    ritp_pkg::ritp_tbl_op_t      tbl_op;

    // stage enables, each stage moves when the next one has room
    assign r_en     = !out_valid_reg || !out_stall;
    assign m_en     = !m_valid_reg || r_en;
    assign e_en     = !e_valid_reg || m_en;
    assign in_stall = clearing || !e_en;
    assign accept   = in_valid && !in_stall;
    assign fire     = e_valid_reg && m_en;

    // item decode
    assign is_pred = (func_reg == ritp_pkg::FUNC_PREDICT);
    assign is_call = kind_reg inside {ritp_pkg::KIND_DIRECT_CALL, ritp_pkg::KIND_INDIRECT_CALL};
    assign is_ind  = kind_reg inside {ritp_pkg::KIND_INDIRECT, ritp_pkg::KIND_INDIRECT_CALL};
    assign is_ret  = (kind_reg == ritp_pkg::KIND_RETURN);

    always_comb
    begin
        ras_op.push       = fire && is_pred && is_call;
        ras_op.pop        = fire && !is_pred && is_ret;
        tbl_op.ind_read   = fire && is_pred && is_ind;
        tbl_op.ind_write  = fire && !is_pred && is_ind;
        tbl_op.hist_shift = fire && !is_pred && (kind_reg == ritp_pkg::KIND_CONDITIONAL);
        tbl_op.size_read  = fire && is_pred && is_ret;
        tbl_op.size_learn = fire && !is_pred && is_ret;
    end

    ritp_ras #(
        .RAS_DEPTH (RAS_DEPTH)
    ) u_ras (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (ras_op),
        .push_addr (addr_reg),
        .top       (top)
    );

    ritp_tables #(
        .INDIRECT_ENTRIES  (INDIRECT_ENTRIES),
        .CALL_SIZE_ENTRIES (CALL_SIZE_ENTRIES)
    ) u_tables (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (tbl_op),
        .branch_address (addr_reg),
        .actual_target  (target_reg),
        .was_taken      (taken_reg),
        .top            (top),
        .ind_rdata      (ind_rdata),
        .size_rdata     (size_rdata),
        .clearing       (clearing)
    );

    // result value: return adds the learned call size to the stack top
    always_comb
    begin
        if (!m_served_reg)
        begin
            pred_next = '0;
        end
        else if (m_is_ret_reg)
        begin
            pred_next = m_top_reg + ritp_pkg::ADDR_W'(size_rdata);
        end
        else
        begin
            pred_next = ind_rdata;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_en)
            begin
                e_valid_reg <= accept;
            end
            if (m_en)
            begin
                m_valid_reg <= e_valid_reg;
            end
            if (r_en)
            begin
                out_valid_reg <= m_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            kind_reg   <= branch_kind;
            addr_reg   <= branch_address;
            target_reg <= actual_target;
            taken_reg  <= was_taken;
        end
        if (fire)
        begin
            m_served_reg <= is_pred && (is_ind || is_ret);
            m_is_ret_reg <= is_ret;
            m_top_reg    <= top;
        end
        if (m_valid_reg && r_en)
        begin
            pred_reg   <= pred_next;
            served_reg <= m_served_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign predicted_target = pred_reg;
    assign served           = served_reg;

endmodule

// ===== tb/sv/tb_return_and_indirect_target_predictor_unit.sv =====
// testbench for the return and indirect target predictor: directed table, random branch streams
`timescale 1ns / 1ps

module tb_return_and_indirect_target_predictor_unit;
    import ritp_pkg::*;

    localparam int IND_ENTRIES  = DEF_INDIRECT_ENTRIES;
    localparam int STACK_DEPTH  = DEF_RAS_DEPTH;
    localparam int SIZE_ENTRIES = DEF_CALL_SIZE_ENTRIES;
    localparam int IND_BITS     = $clog2(IND_ENTRIES);
    localparam int STACK_BITS   = $clog2(STACK_DEPTH);
    localparam int SIZE_BITS    = $clog2(SIZE_ENTRIES);
    localparam int TOTAL_ITEMS  = 1575;
    localparam int REPORT_LIMIT = 10;
    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    // one branch request as it travels on the input side
    typedef struct packed {
        logic              func;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] target;
        logic              taken;
    } branch_req_t;

    // one target guess as it leaves the block
    typedef struct packed {
        logic [ADDR_W-1:0] target;
        logic              served;
    } target_guess_t;

    // directed row: request plus an optional typed-in answer
    typedef struct packed {
        branch_req_t   req;
        logic          typed_in;
        target_guess_t answer;
    } branch_row_t;

    logic              clk;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic              func           = FUNC_PREDICT;
    logic [KIND_W-1:0] branch_kind    = KIND_NONE;
    logic [ADDR_W-1:0] branch_address = '0;
    logic [ADDR_W-1:0] actual_target  = '0;
    logic              was_taken      = 1'b0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [ADDR_W-1:0] predicted_target;
    logic              served;

    // predictor state
    logic [ADDR_W-1:0]     ind_table  [IND_ENTRIES];
    logic [IND_BITS-1:0]   hist;
    logic [ADDR_W-1:0]     ret_stack  [STACK_DEPTH];
    logic [STACK_BITS-1:0] ret_sp;
    logic [SIZE_W-1:0]     size_table [SIZE_ENTRIES];

    target_guess_t expected_targets[$];
    int unsigned   sent;
    int unsigned   directed_sent;
    int unsigned   results_seen;
    int unsigned   served_seen;
    int unsigned   mismatches;
    bit            steady;

    return_and_indirect_target_predictor_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .branch_kind      (branch_kind),
        .branch_address   (branch_address),
        .actual_target    (actual_target),
        .was_taken        (was_taken),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .predicted_target (predicted_target),
        .served           (served)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // reset held low at the start, then released
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard limit on run length
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // target guess for one request, advancing the predictor state
    function automatic target_guess_t predict_branch_target(input branch_req_t q);
        target_guess_t       g;
        logic [IND_BITS-1:0] slot;
        logic [ADDR_W-1:0]   head;
        logic [ADDR_W-1:0]   popped;
        logic [ADDR_W-1:0]   span;
        g    = '0;
        slot = q.addr[IND_BITS+1:2] ^ hist;
        if (q.func == FUNC_PREDICT)
        begin
            // calls push their own address
            if (q.kind == KIND_DIRECT_CALL || q.kind == KIND_INDIRECT_CALL)
            begin
                ret_sp = ret_sp + 1'b1;
                ret_stack[ret_sp] = q.addr;
            end
            // return: top of stack plus learned call size, wrapping at 2^64
            if (q.kind == KIND_RETURN)
            begin
                head     = ret_stack[ret_sp];
                g.target = head + ADDR_W'(size_table[head[SIZE_BITS-1:0]]);
                g.served = 1'b1;
            end
            else if (q.kind == KIND_INDIRECT || q.kind == KIND_INDIRECT_CALL)
            begin
                g.target = ind_table[slot];
                g.served = 1'b1;
            end
        end
        else
        begin
            if (q.kind == KIND_INDIRECT || q.kind == KIND_INDIRECT_CALL)
                ind_table[slot] = q.target;
            if (q.kind == KIND_CONDITIONAL)
                hist = {hist[IND_BITS-2:0], q.taken};
            // pop clears the entry; near returns teach the call size
            if (q.kind == KIND_RETURN)
            begin
                popped            = ret_stack[ret_sp];
                ret_stack[ret_sp] = '0;
                ret_sp            = ret_sp - 1'b1;
                span = (popped > q.target) ? popped - q.target : q.target - popped;
                if (span <= ADDR_W'(MAX_LEARNED_SIZE))
                    size_table[popped[SIZE_BITS-1:0]] = span[SIZE_W-1:0];
            end
        end
        return g;
    endfunction

    // present one item, wait for the handshake, record what should come back
    task automatic send_item(input branch_req_t q, input logic typed_in,
                             input target_guess_t answer);
        int unsigned   gap;
        target_guess_t g;
        if (sent % 100 == 0)
            steady = ($urandom_range(0, 3) == 0);
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= q.func;
        branch_kind    <= q.kind;
        branch_address <= q.addr;
        actual_target  <= q.target;
        was_taken      <= q.taken;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        g = predict_branch_target(q);
        expected_targets.push_back(typed_in ? answer : g);
        sent++;
    endtask

    // result side stall: a random hold after each accepted item
    always @(posedge clk)
    begin : result_hold
        int unsigned hold;
        int unsigned hold_left;
        if (out_valid && !out_stall)
        begin
            hold      = steady ? 0 : $urandom_range(0, 9);
            hold_left = hold;
            out_stall <= (hold != 0);
        end
        else if (hold_left > 1)
            hold_left = hold_left - 1;
        else
        begin
            hold_left = 0;
            out_stall <= 1'b0;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        target_guess_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (served)
                served_seen++;
            if (expected_targets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: target %h served %b",
                             predicted_target, served);
            end
            else
            begin
                want = expected_targets.pop_front();
                if (want.target !== predicted_target || want.served !== served)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch at result %0d: expected target %h served %b, got target %h served %b",
                                 results_seen, want.target, want.served,
                                 predicted_target, served);
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        branch_row_t       rows[$];
        branch_req_t       burst[$];
        branch_req_t       q;
        logic [ADDR_W-1:0] addr_pool[16];
        logic [ADDR_W-1:0] head;
        int unsigned       pick;
        int unsigned       off;

        // predictor reset state
        foreach (ind_table[i])
            ind_table[i] = '0;
        foreach (ret_stack[i])
            ret_stack[i] = '0;
        foreach (size_table[i])
            size_table[i] = RESET_CALL_SIZE;
        hist   = '0;
        ret_sp = '0;
        steady = 1'b0;
        foreach (addr_pool[i])
            addr_pool[i] = {$urandom, $urandom};

        // directed rows: request, typed-in flag, answer
        rows.push_back('{'{FUNC_PREDICT, KIND_RETURN, 64'd0, 64'd0, 1'b0}, 1'b1, '{64'd4, 1'b1}});
        rows.push_back('{'{FUNC_PREDICT, KIND_INDIRECT, ALL_ONES, 64'd0, 1'b0}, 1'b1, '{64'd0, 1'b1}});
        rows.push_back('{'{FUNC_PREDICT, KIND_NONE, ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_DIRECT_JUMP, ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_CONDITIONAL, ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_OTHER, ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_INDIRECT, ALL_ONES, ALL_ONES, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_INDIRECT, ALL_ONES, 64'd0, 1'b0}, 1'b1, '{ALL_ONES, 1'b1}});
        rows.push_back('{'{FUNC_UPDATE, KIND_CONDITIONAL, 64'd0, 64'd0, 1'b1}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_INDIRECT, ALL_ONES, 64'd0, 1'b0}, 1'b0, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_DIRECT_CALL, 64'h1000, 64'd0, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_RETURN, 64'd0, 64'd0, 1'b0}, 1'b1, '{64'h1004, 1'b1}});
        rows.push_back('{'{FUNC_UPDATE, KIND_RETURN, 64'd0, 64'h1006, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_DIRECT_CALL, 64'h1000, 64'd0, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_RETURN, 64'd0, 64'd0, 1'b0}, 1'b0, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_RETURN, 64'd0, 64'h2000, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_INDIRECT_CALL, ALL_ONES, 64'd0, 1'b0}, 1'b0, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_RETURN, 64'd0, 64'd0, 1'b0}, 1'b0, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_RETURN, 64'd0, 64'hFFFF_FFFF_FFFF_FFF5, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_RETURN, 64'd0, 64'd0, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_PREDICT, KIND_RETURN, 64'd0, 64'd0, 1'b0}, 1'b0, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_CONDITIONAL, ALL_ONES, ALL_ONES, 1'b0}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_DIRECT_CALL, 64'h40, ALL_ONES, 1'b1}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_OTHER, ALL_ONES, 64'd0, 1'b1}, 1'b1, '{64'd0, 1'b0}});
        rows.push_back('{'{FUNC_UPDATE, KIND_DIRECT_JUMP, ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{64'd0, 1'b0}});

        wait (rst_n);
        @(posedge clk);

        // directed part
        foreach (rows[i])
            send_item(rows[i].req, rows[i].typed_in, rows[i].answer);
        directed_sent = sent;

        // random part: mostly calls, returns and indirect read/train/read triples, some noise
        while (sent < TOTAL_ITEMS)
        begin
            burst.delete();
            pick = $urandom_range(0, 99);
            q.func   = FUNC_PREDICT;
            q.kind   = KIND_NONE;
            q.addr   = addr_pool[$urandom_range(0, 15)];
            q.target = {$urandom, $urandom};
            q.taken  = 1'($urandom_range(0, 1));
            if (pick < 20)
            begin
                // call pushes
                q.kind = $urandom_range(0, 1) ? KIND_DIRECT_CALL : KIND_INDIRECT_CALL;
                burst.push_back(q);
            end
            else if (pick < 38)
            begin
                // return prediction then its resolution, mostly near the call
                q.kind = KIND_RETURN;
                burst.push_back(q);
                head   = ret_stack[ret_sp];
                off    = $urandom_range(0, 12);
                q.func = FUNC_UPDATE;
                q.target = $urandom_range(0, 1) ? head + ADDR_W'(off) : head - ADDR_W'(off);
                if ($urandom_range(0, 4) == 0)
                    q.target = {$urandom, $urandom};
                burst.push_back(q);
            end
            else if (pick < 58)
            begin
                // indirect read, train, read back
                q.kind = $urandom_range(0, 1) ? KIND_INDIRECT : KIND_INDIRECT_CALL;
                burst.push_back(q);
                q.func = FUNC_UPDATE;
                burst.push_back(q);
                q.func = FUNC_PREDICT;
                burst.push_back(q);
            end
            else if (pick < 72)
            begin
                // history shift
                q.func = FUNC_UPDATE;
                q.kind = KIND_CONDITIONAL;
                burst.push_back(q);
            end
            else if (pick < 80)
            begin
                // kinds that are never served
                case ($urandom_range(0, 3))
                    0: q.kind = KIND_NONE;
                    1: q.kind = KIND_DIRECT_JUMP;
                    2: q.kind = KIND_CONDITIONAL;
                    default: q.kind = KIND_OTHER;
                endcase
                burst.push_back(q);
            end
            else
            begin
                // noise
                q.func = 1'($urandom_range(0, 1));
                q.kind = KIND_W'($urandom_range(0, 7));
                q.addr = {$urandom, $urandom};
                burst.push_back(q);
            end
            if (pick % 16 == 0)
                addr_pool[$urandom_range(0, 15)] = {$urandom, $urandom};
            foreach (burst[i])
                send_item(burst[i], 1'b0, '0);
        end

        // drain
        in_valid <= 1'b0;
        wait (expected_targets.size() == 0);
        repeat (8) @(posedge clk);

        $display("run: %0d items (%0d directed), %0d results, %0d served predictions",
                 sent, directed_sent, results_seen, served_seen);
        $display("run: %0d mismatches", mismatches);
        if (mismatches == 0 && expected_targets.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ritp_pkg.sv
rtl/ritp_ras.sv
rtl/ritp_tables.sv
rtl/return_and_indirect_target_predictor_unit.sv
tb/sv/tb_return_and_indirect_target_predictor_unit.sv
